>>> sv/blz_pkg.sv
// Shared types and constants for the backward LZSS decompressor.
// No dependencies.
package blz_pkg;

   localparam int HISTORY_DEPTH_DEF = 8192;
   localparam int OUTPUT_SIZE_W     = 28;
   localparam int LEN_W             = 5;
   localparam int DIST_W            = 13;
   localparam logic [LEN_W-1:0]  LEN_BIAS   = 5'd3;
   localparam logic [DIST_W-1:0] DIST_BIAS  = 13'd3;
   localparam logic [3:0]        FLAGS_FULL = 4'd8;

   localparam logic [2:0] STATUS_DATA      = 3'd0;
   localparam logic [2:0] STATUS_DONE      = 3'd1;
   localparam logic [2:0] STATUS_DISTANCE  = 3'd2;
   localparam logic [2:0] STATUS_OVERFLOW  = 3'd3;
   localparam logic [2:0] STATUS_TRUNCATED = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COPY,
      ST_DONE
   } blz_state_type;

   typedef enum logic [1:0] {
      PH_CTRL,
      PH_ITEM,
      PH_LOW
   } blz_phase_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [2:0] status;
      logic       run_last;
   } blz_result_type;

endpackage

>>> sv/blz_history_ram.sv
// History ring of output bytes: one write port, one registered read port.
// Depends on nothing but its parameter.
module blz_history_ram #(
   parameter int DEPTH  = 8192,
   parameter int ADDR_W = 13
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/blz_out_stage.sv
// Output register for result items, with valid/stall toward the receiver.
// Depends on blz_pkg.
module blz_out_stage
   import blz_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  blz_result_type res,
   output logic           slot_free,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output logic [7:0]     rsp_out_byte,
   output logic [2:0]     rsp_status,
   output logic           rsp_run_last
);

   logic           valid_ff;
   logic           valid_in;
   blz_result_type res_ff;

   assign slot_free = !valid_ff || !rsp_stall;
   assign valid_in  = push || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         res_ff <= res;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = res_ff.out_byte;
   assign rsp_status   = res_ff.status;
   assign rsp_run_last = res_ff.run_last;

endmodule

>>> sv/backward_lzss_decompressor_unit.sv
// Backward LZSS decompressor: parser, copy sequencer and history ring.
// Literal and control bytes are handled as they are accepted; a reference
// copies its length (3..18) in bytes, one history read and one write per byte.
// Frame end adds a status item. Output register stalls slow it.
// Synchronous reset clears control state; the history ring is not cleared.
// Depends on blz_pkg, blz_history_ram and blz_out_stage.
module backward_lzss_decompressor_unit
   import blz_pkg::*;
#(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [7:0]               req_in_byte,
   input  logic                     req_in_last,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [7:0]               rsp_out_byte,
   output logic [2:0]               rsp_status,
   output logic                     rsp_run_last,
   input  logic                     csr_wr_en,
   input  logic [OUTPUT_SIZE_W-1:0] csr_wr_data
);

   localparam int PTR_W  = $clog2(HISTORY_DEPTH);
   localparam int PTR_W1 = PTR_W + 1;
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(HISTORY_DEPTH - 1);
   localparam logic [PTR_W:0]   DEPTH_EXT = PTR_W1'(HISTORY_DEPTH);

   blz_state_type            state_ff, state_in;
   blz_phase_type            phase_ff, phase_in;
   logic [7:0]               flag_byte_ff, flag_byte_in;
   logic [3:0]               flags_left_ff, flags_left_in;
   logic [7:0]               held_high_ff, held_high_in;
   logic                     halted_ff, halted_in;
   logic [OUTPUT_SIZE_W-1:0] emitted_ff, emitted_in;
   logic [OUTPUT_SIZE_W-1:0] output_size_ff;
   logic [PTR_W-1:0]         wp_ff, wp_in;
   logic [PTR_W-1:0]         rp_ff, rp_in;
   logic [LEN_W-1:0]         rd_left_ff, rd_left_in;
   logic [LEN_W-1:0]         emit_left_ff, emit_left_in;
   logic                     pend_ff, pend_in;
   logic                     copy_last_ff, copy_last_in;

   logic                     accept;
   logic                     slot_free;
   logic                     push;
   blz_result_type           res;
   logic                     wr_en;
   logic [7:0]               wr_data;
   logic                     rd_en;
   logic [7:0]               rd_data;
   logic [OUTPUT_SIZE_W-1:0] remaining;
   logic [LEN_W-1:0]         len;
   logic [DIST_W-1:0]        ref_dist;
   logic [PTR_W:0]           wp_ext;
   logic [PTR_W:0]           dist_ext;
   logic [PTR_W:0]           rd_start;
   logic [PTR_W-1:0]         wp_next;
   logic [PTR_W-1:0]         rp_next;
   logic [3:0]               flags_dec;

   assign req_stall = !(state_ff == ST_IDLE && slot_free);
   assign accept    = req_valid && !req_stall;

   assign remaining = (output_size_ff > emitted_ff) ? output_size_ff - emitted_ff : '0;
   assign len       = {1'b0, held_high_ff[7:4]} + LEN_BIAS;
   assign ref_dist  = {1'b0, held_high_ff[3:0], req_in_byte} + DIST_BIAS;
   assign wp_ext    = {1'b0, wp_ff};
   assign dist_ext  = PTR_W1'(ref_dist);
   assign rd_start  = (wp_ext >= dist_ext) ? wp_ext - dist_ext
                                           : wp_ext + DEPTH_EXT - dist_ext;
   assign wp_next   = (wp_ff == LAST_PTR) ? '0 : wp_ff + 1'b1;
   assign rp_next   = (rp_ff == LAST_PTR) ? '0 : rp_ff + 1'b1;
   assign flags_dec = (flags_left_ff != 4'd0) ? flags_left_ff - 4'd1 : 4'd0;

   always_comb begin
      logic [2:0] err;
      logic       busy_next;
      logic       emit;
      logic       issue;
      logic       restart;

      err       = STATUS_DATA;
      busy_next = 1'b0;
      emit      = 1'b0;
      issue     = 1'b0;
      restart   = 1'b0;

      state_in      = state_ff;
      phase_in      = phase_ff;
      flag_byte_in  = flag_byte_ff;
      flags_left_in = flags_left_ff;
      held_high_in  = held_high_ff;
      halted_in     = halted_ff;
      emitted_in    = emitted_ff;
      wp_in         = wp_ff;
      rp_in         = rp_ff;
      rd_left_in    = rd_left_ff;
      emit_left_in  = emit_left_ff;
      pend_in       = pend_ff;
      copy_last_in  = copy_last_ff;

      push    = 1'b0;
      res     = '{out_byte: 8'd0, status: STATUS_DATA, run_last: 1'b0};
      wr_en   = 1'b0;
      wr_data = req_in_byte;
      rd_en   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (halted_ff) begin
                  restart = req_in_last;
               end else begin
                  if (phase_ff == PH_LOW) begin
                     if (remaining < OUTPUT_SIZE_W'(len)) begin
                        err = STATUS_OVERFLOW;
                     end else if (OUTPUT_SIZE_W'(ref_dist) > emitted_ff) begin
                        err = STATUS_DISTANCE;
                     end else begin
                        busy_next     = 1'b1;
                        state_in      = ST_COPY;
                        copy_last_in  = req_in_last;
                        rd_left_in    = len;
                        emit_left_in  = len;
                        rp_in         = rd_start[PTR_W-1:0];
                        pend_in       = 1'b0;
                        flag_byte_in  = {flag_byte_ff[6:0], 1'b0};
                        flags_left_in = flags_dec;
                        phase_in      = (flags_dec != 4'd0) ? PH_ITEM : PH_CTRL;
                     end
                  end else if (phase_ff == PH_CTRL || flags_left_ff == 4'd0) begin
                     flag_byte_in  = req_in_byte;
                     flags_left_in = FLAGS_FULL;
                     phase_in      = PH_ITEM;
                  end else if (remaining != '0) begin
                     if (flag_byte_ff[7]) begin
                        held_high_in = req_in_byte;
                        phase_in     = PH_LOW;
                        if (req_in_last) begin
                           err = STATUS_TRUNCATED;
                        end
                     end else begin
                        busy_next     = 1'b1;
                        wr_en         = 1'b1;
                        push          = 1'b1;
                        res.out_byte  = req_in_byte;
                        res.run_last  = !req_in_last;
                        wp_in         = wp_next;
                        emitted_in    = emitted_ff + 1'b1;
                        flag_byte_in  = {flag_byte_ff[6:0], 1'b0};
                        flags_left_in = flags_dec;
                        phase_in      = (flags_dec != 4'd0) ? PH_ITEM : PH_CTRL;
                        if (req_in_last) begin
                           state_in = ST_DONE;
                        end
                     end
                  end
                  if (err != STATUS_DATA) begin
                     push      = 1'b1;
                     res       = '{out_byte: 8'd0, status: err, run_last: 1'b1};
                     halted_in = 1'b1;
                     restart   = req_in_last;
                  end else if (req_in_last && !busy_next) begin
                     push    = 1'b1;
                     res     = '{out_byte: 8'd0, status: STATUS_DONE, run_last: 1'b1};
                     restart = 1'b1;
                  end
               end
            end
         end
         ST_COPY: begin
            emit  = pend_ff && slot_free;
            issue = (rd_left_ff != '0) && (!pend_ff || emit);
            wr_data = rd_data;
            if (emit) begin
               wr_en        = 1'b1;
               push         = 1'b1;
               res.out_byte = rd_data;
               res.run_last = (emit_left_ff == LEN_W'(1)) && !copy_last_ff;
               wp_in        = wp_next;
               emitted_in   = emitted_ff + 1'b1;
               emit_left_in = emit_left_ff - 1'b1;
               if (emit_left_ff == LEN_W'(1)) begin
                  state_in = copy_last_ff ? ST_DONE : ST_IDLE;
               end
            end
            if (issue) begin
               rd_en      = 1'b1;
               rp_in      = rp_next;
               rd_left_in = rd_left_ff - 1'b1;
            end
            pend_in = issue || (pend_ff && !emit);
         end
         ST_DONE: begin
            if (slot_free) begin
               push     = 1'b1;
               res      = '{out_byte: 8'd0, status: STATUS_DONE, run_last: 1'b1};
               restart  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (restart) begin
         emitted_in    = '0;
         flag_byte_in  = 8'd0;
         flags_left_in = 4'd0;
         phase_in      = PH_CTRL;
         held_high_in  = 8'd0;
         halted_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         phase_ff       <= PH_CTRL;
         flag_byte_ff   <= 8'd0;
         flags_left_ff  <= 4'd0;
         held_high_ff   <= 8'd0;
         halted_ff      <= 1'b0;
         emitted_ff     <= '0;
         output_size_ff <= '0;
         wp_ff          <= '0;
         rd_left_ff     <= '0;
         emit_left_ff   <= '0;
         pend_ff        <= 1'b0;
         copy_last_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         flag_byte_ff  <= flag_byte_in;
         flags_left_ff <= flags_left_in;
         held_high_ff  <= held_high_in;
         halted_ff     <= halted_in;
         emitted_ff    <= emitted_in;
         wp_ff         <= wp_in;
         rd_left_ff    <= rd_left_in;
         emit_left_ff  <= emit_left_in;
         pend_ff       <= pend_in;
         copy_last_ff  <= copy_last_in;
         if (csr_wr_en) begin
            output_size_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rp_ff <= rp_in;
   end

   blz_history_ram #(
      .DEPTH  (HISTORY_DEPTH),
      .ADDR_W (PTR_W)
   ) u_history (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wp_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rp_ff),
      .rd_data (rd_data)
   );

   blz_out_stage u_out (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .res          (res),
      .slot_free    (slot_free),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_status   (rsp_status),
      .rsp_run_last (rsp_run_last)
   );

endmodule

>>> tb/backward_lzss_decompressor_unit_test.sv
// Self-checking bench for backward_lzss_decompressor_unit: a scoreboard class
// decodes every accepted item and compares each output item against it.
// Depends on blz_pkg and the backward_lzss_decompressor_unit RTL.
module backward_lzss_decompressor_unit_test;
   import blz_pkg::*;

   class blz_output_scoreboard;
      logic [7:0]               ring [HISTORY_DEPTH_DEF];
      logic [12:0]              ring_ptr;
      logic [OUTPUT_SIZE_W-1:0] budget;
      logic [OUTPUT_SIZE_W-1:0] produced;
      logic [7:0]               ctrl_bits;
      logic [3:0]               ctrl_left;
      blz_phase_type            phase;
      logic [7:0]               ref_high;
      bit                       skipping;
      blz_result_type           step_out [$];
      blz_result_type           due_results [$];
      int                       mismatches;

      function new();
         ring_ptr   = '0;
         budget     = '0;
         mismatches = 0;
         new_frame();
      endfunction

      function void new_frame();
         produced  = '0;
         ctrl_bits = '0;
         ctrl_left = '0;
         phase     = PH_CTRL;
         ref_high  = '0;
         skipping  = 1'b0;
      endfunction

      function void emit_data(logic [7:0] b);
         ring[ring_ptr] = b;
         ring_ptr++;
         produced++;
         step_out.push_back(blz_result_type'{b, STATUS_DATA, 1'b0});
      endfunction

      function void advance_flag();
         ctrl_bits = ctrl_bits << 1;
         if (ctrl_left > 0) ctrl_left--;
         phase = (ctrl_left > 0) ? PH_ITEM : PH_CTRL;
      endfunction

      function void absorb_input(logic [7:0] b, logic l);
         logic [OUTPUT_SIZE_W-1:0] room;
         logic [4:0]               span;
         logic [12:0]              back;
         logic [2:0]               fault;
         bit                       faulted;
         int                       k;
         step_out.delete();
         faulted = 1'b0;
         fault   = STATUS_DATA;
         if (skipping) begin
            if (l) new_frame();
            return;
         end
         room = (budget > produced) ? budget - produced : '0;
         if (phase == PH_LOW) begin
            span = {1'b0, ref_high[7:4]} + LEN_BIAS;
            back = {1'b0, ref_high[3:0], b} + DIST_BIAS;
            if (room < span) begin
               faulted = 1'b1;
               fault   = STATUS_OVERFLOW;
            end else if (back > produced) begin
               faulted = 1'b1;
               fault   = STATUS_DISTANCE;
            end else begin
               for (k = 0; k < span; k++) emit_data(ring[ring_ptr - back]);
               advance_flag();
            end
         end else if (phase == PH_CTRL || ctrl_left == 0) begin
            ctrl_bits = b;
            ctrl_left = FLAGS_FULL;
            phase     = PH_ITEM;
         end else if (room > 0) begin
            if (ctrl_bits[7]) begin
               ref_high = b;
               phase    = PH_LOW;
               if (l) begin
                  faulted = 1'b1;
                  fault   = STATUS_TRUNCATED;
               end
            end else begin
               emit_data(b);
               advance_flag();
            end
         end
         if (faulted) begin
            step_out.push_back(blz_result_type'{8'h00, fault, 1'b0});
            skipping = 1'b1;
            if (l) new_frame();
         end else if (l) begin
            step_out.push_back(blz_result_type'{8'h00, STATUS_DONE, 1'b0});
            new_frame();
         end
         if (step_out.size() > 0) step_out[step_out.size() - 1].run_last = 1'b1;
         foreach (step_out[i]) due_results.push_back(step_out[i]);
      endfunction

      function void match_result(blz_result_type got);
         blz_result_type want;
         if (due_results.size() == 0) begin
            $error("unexpected item: out_byte %0h status %0d run_last %0b",
                   got.out_byte, got.status, got.run_last);
            mismatches++;
            return;
         end
         want = due_results.pop_front();
         if (got.out_byte !== want.out_byte) begin
            $error("out_byte expected %0h actual %0h", want.out_byte, got.out_byte);
            mismatches++;
         end
         if (got.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, got.status);
            mismatches++;
         end
         if (got.run_last !== want.run_last) begin
            $error("run_last expected %0b actual %0b", want.run_last, got.run_last);
            mismatches++;
         end
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [7:0]               req_in_byte;
   logic                     req_in_last;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [7:0]               rsp_out_byte;
   logic [2:0]               rsp_status;
   logic                     rsp_run_last;
   logic                     csr_wr_en;
   logic [OUTPUT_SIZE_W-1:0] csr_wr_data;

   blz_output_scoreboard board;
   bit  quiet;
   bit  send_calm;
   bit  hold_request;
   int  items_sent;

   backward_lzss_decompressor_unit u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_byte  (req_in_byte),
      .req_in_last  (req_in_last),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_status   (rsp_status),
      .rsp_run_last (rsp_run_last),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wr_en) board.budget = csr_wr_data;
         if (req_valid && !req_stall) board.absorb_input(req_in_byte, req_in_last);
         if (rsp_valid && !rsp_stall) begin
            board.match_result(blz_result_type'{rsp_out_byte, rsp_status, rsp_run_last});
         end
      end
   end

   // output side: random stall bursts, calm stretches, one long hold-off
   initial begin
      int  rest;
      int  hold;
      bit  calm;
      rest = 0;
      hold = 0;
      calm = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold = 300;
         end
         if ($urandom_range(0, 149) == 0) calm = !calm;
         if (hold > 0) begin
            hold--;
            rsp_stall <= 1'b1;
         end else if (rest > 0) begin
            rest--;
            rsp_stall <= 1'b1;
         end else if (!quiet && !calm && $urandom_range(0, 7) == 0) begin
            rest = $urandom_range(0, 14);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // stall is sampled mid-cycle so the accepting edge is judged on settled values
   task automatic send_item(input logic [7:0] b, input logic l);
      logic stalled;
      if (!quiet && !send_calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      req_in_last <= l;
      do begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end while (stalled);
   endtask

   task automatic send_run(input logic [7:0] seq [$]);
      send_calm = ($urandom_range(0, 3) == 0);
      foreach (seq[i]) send_item(seq[i], i == seq.size() - 1);
      items_sent += seq.size();
   endtask

   // waits until every expected item is out, then lets a trailing item settle
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.due_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_budget(input logic [OUTPUT_SIZE_W-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // kind 0: bad distance at the end, 1: cut reference, 2: noise, else clean
   task automatic play_frame(input int target);
      logic [7:0] seq [$];
      logic [7:0] ctrl;
      int         made;
      int         slot;
      int         k;
      int         span;
      int         raw;
      int         kind;
      made = 0;
      slot = 0;
      k    = -1;
      ctrl = 8'h00;
      kind = $urandom_range(0, 9);
      if (kind == 2) begin
         repeat ($urandom_range(1, 8)) seq.push_back(8'($urandom));
      end else begin
         while (made < target) begin
            slot = seq.size();
            seq.push_back(8'h00);
            ctrl = 8'h00;
            k    = 7;
            while (k >= 0 && made < target) begin
               if (made >= 3 && $urandom_range(0, 2) == 0) begin
                  ctrl[k] = 1'b1;
                  span    = $urandom_range(0, 15);
                  raw     = $urandom_range(0, (made - 3 > 4095) ? 4095 : made - 3);
                  seq.push_back({span[3:0], raw[11:8]});
                  seq.push_back(raw[7:0]);
                  made += span + 3;
               end else begin
                  seq.push_back(8'($urandom));
                  made++;
               end
               k--;
            end
            seq[slot] = ctrl;
         end
         if (kind <= 1) begin
            if (k < 0) begin
               slot = seq.size();
               seq.push_back(8'h00);
               ctrl = 8'h00;
               k    = 7;
            end
            ctrl[k]   = 1'b1;
            seq[slot] = ctrl;
            raw       = (made > 4095) ? 4095 : made;
            seq.push_back({4'($urandom_range(0, 15)), raw[11:8]});
            if (kind == 0) begin
               seq.push_back(raw[7:0]);
               repeat ($urandom_range(0, 3)) seq.push_back(8'($urandom));
            end
         end
      end
      if (seq.size() == 0) seq.push_back(8'($urandom));
      send_run(seq);
   endtask

   initial begin
      logic [7:0]               seq [$];
      logic [OUTPUT_SIZE_W-1:0] level;
      int                       round;
      int                       pick;
      board = new();
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_in_byte <= 8'h00;
      req_in_last <= 1'b0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // zero budget: flagged item dropped silently, frame still closes
      write_budget('0);
      seq = {8'hC3, 8'h9A};
      send_run(seq);

      // full budget: literals, longest reference, farthest distance on the last item
      drain();
      write_budget({OUTPUT_SIZE_W{1'b1}});
      seq = {8'h18, 8'hFF, 8'h00, 8'h5A, 8'hF0, 8'h00, 8'h0F, 8'hFF};
      send_run(seq);
      seq = {8'h80, 8'hF7};
      send_run(seq);
      seq = {8'h01, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h77, 8'h40, 8'h04,
             8'h00};
      send_run(seq);

      // reference longer than what is left of the budget
      drain();
      write_budget(28'd5);
      seq = {8'h08, 8'h01, 8'h02, 8'h03, 8'h04, 8'h10, 8'h00, 8'h7E};
      send_run(seq);

      round = 0;
      while (items_sent < 380) begin
         quiet = (items_sent >= 320);
         drain();
         pick = $urandom_range(0, 19);
         if (round == 0 || pick < 8) level = {OUTPUT_SIZE_W{1'b1}};
         else if (pick < 9) level = '0;
         else if (pick < 14) level = OUTPUT_SIZE_W'($urandom_range(0, 80));
         else level = OUTPUT_SIZE_W'($urandom);
         write_budget(level);
         if (round == 0) begin
            hold_request = 1'b1;
            repeat (2) play_frame(250);
         end else begin
            repeat ($urandom_range(1, 3)) begin
               pick = $urandom_range(0, 19);
               play_frame((pick < 3) ? $urandom_range(100, 300) : $urandom_range(0, 60));
            end
         end
         round++;
      end

      drain();
      if (board.mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
